FILE: hw/rtl/ppd_pkg.sv
package ppd_pkg;

	// Widths fixed by the byte stream and the result fields.
	localparam int DATA_W  = 8;
	localparam int IDX_W   = 7;
	localparam int MCNT_W  = 2;
	localparam int PAT_W   = 32;
	localparam int TDATA_W = 32;

	// Configuration register indexes.
	localparam int CFG_ADDR_W = 1;
	localparam logic [CFG_ADDR_W-1:0] CFG_PREAMBLE  = 1'd0;
	localparam logic [CFG_ADDR_W-1:0] CFG_POSTAMBLE = 1'd1;

	// One result transaction before packing onto the master-side bus.
	typedef struct packed {
		logic [DATA_W-1:0] data_byte;
		logic              stored;
		logic [IDX_W-1:0]  store_index;
		logic              frame_start;
		logic              frame_done;
		logic [IDX_W-1:0]  payload_length;
		logic              payload_valid;
		logic              overflow;
	} result_t;

endpackage

FILE: hw/rtl/ppd_match.sv
module ppd_match #(
	parameter int LEN = 2
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic [ppd_pkg::DATA_W-1:0] rx_byte,
	input  logic [ppd_pkg::PAT_W-1:0]  pattern,
	output logic                       hit
);
	import ppd_pkg::*;

	localparam logic [MCNT_W-1:0] LAST_IDX = MCNT_W'(LEN - 1);

	logic [MCNT_W-1:0] count_q;
	logic [MCNT_W-1:0] count_d;
	logic [DATA_W-1:0] exp_byte;
	logic              eq_cur;
	logic              eq_first;

	// Pattern byte expected at the current match position.
	assign exp_byte = pattern[count_q*DATA_W +: DATA_W];
	assign eq_cur   = (rx_byte == exp_byte);
	assign eq_first = (rx_byte == pattern[DATA_W-1:0]);

	// Advance on a match; on a mismatch restart, checking the first pattern byte only.
	always_comb begin
		hit     = 1'b0;
		count_d = count_q;
		if (eq_cur) begin
			if (count_q >= LAST_IDX) begin
				hit     = 1'b1;
				count_d = '0;
			end else begin
				count_d = count_q + 1'b1;
			end
		end else begin
			count_d = eq_first ? MCNT_W'(1) : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (en) begin
			count_q <= count_d;
		end
	end

	// The match position never passes the last byte of the pattern.
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= LAST_IDX)
		else $error("match position beyond pattern length");

	// A completed pattern always restarts the match position.
	a_hit_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(en && hit) |=> (count_q == '0))
		else $error("match position not restarted after completion");

	// A byte equal to neither the expected nor the first pattern byte restarts the match.
	a_step: assert property (@(posedge clk) disable iff (!arst_n)
		(en && !eq_cur && !eq_first) |=> (count_q == '0))
		else $error("match position kept after a mismatch");

endmodule

FILE: hw/rtl/preamble_postamble_deframer_core.sv
// Preamble/postamble deframer. One received byte enters per s_ transaction and
// leaves one result per m_ transaction, a new byte every clock cycle while the
// output is taken; each byte passes an input register, then a result register.
// s_tready drops only while a finished result is held and m_tready is low. While
// collecting, each byte is reported with its buffer position until the buffer of
// MAX_PAYLOAD + POST_LEN bytes is full, after which overflow is flagged and
// collection stops. A completed preamble starts collection at position zero; a
// completed postamble raises m_tlast with the payload length (count minus
// POST_LEN, never below zero) and whether collection was still running. A mismatch
// rechecks the byte against the first pattern byte only. Pattern registers are
// written through cfg_we/cfg_addr/cfg_wdata and must only change while idle.
module preamble_postamble_deframer_core #(
	parameter int PRE_LEN     = 2,
	parameter int POST_LEN    = 2,
	parameter int MAX_PAYLOAD = 64
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [ppd_pkg::CFG_ADDR_W-1:0] cfg_addr,
	input  logic [ppd_pkg::PAT_W-1:0]      cfg_wdata,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// s_tdata: rx_byte[7:0]
	input  logic [ppd_pkg::DATA_W-1:0]     s_tdata,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// m_tdata: data_byte[7:0], stored[8], store_index[15:9], frame_start[16],
	// payload_length[23:17], payload_valid[24], overflow[25], zeros[31:26]
	output logic [ppd_pkg::TDATA_W-1:0]    m_tdata,
	// m_tlast: frame_done
	output logic                           m_tlast
);
	import ppd_pkg::*;

	localparam int BUF_SIZE = MAX_PAYLOAD + POST_LEN;
	localparam int CNT_W    = $clog2(BUF_SIZE + 1);
	localparam logic [CNT_W-1:0] BUF_SIZE_C = CNT_W'(BUF_SIZE);
	localparam logic [CNT_W-1:0] POST_LEN_C = CNT_W'(POST_LEN);
	localparam int PACK_W   = 2 * DATA_W - DATA_W + 2 * IDX_W + 4;

	logic [PAT_W-1:0]  pre_pat_q;
	logic [PAT_W-1:0]  post_pat_q;
	logic              valid_s1;
	logic [DATA_W-1:0] rx_byte_s1;
	logic              out_valid_q;
	result_t           res_q;
	result_t           res_d;
	logic              collecting_q;
	logic [CNT_W-1:0]  byte_count_q;
	logic              collecting_d;
	logic [CNT_W-1:0]  byte_count_d;
	logic              advance;
	logic              pre_hit;
	logic              post_hit;

	// Pattern registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pre_pat_q  <= '0;
			post_pat_q <= '0;
		end else if (cfg_we) begin
			case (cfg_addr)
				CFG_PREAMBLE:  pre_pat_q  <= cfg_wdata;
				CFG_POSTAMBLE: post_pat_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// The stage-one byte moves on whenever the result register is free or being emptied.
	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			rx_byte_s1 <= s_tdata;
		end
	end

	// Pattern matchers, stepped once per processed byte.
	ppd_match #(.LEN(PRE_LEN)) u_pre_match (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (advance),
		.rx_byte (rx_byte_s1),
		.pattern (pre_pat_q),
		.hit     (pre_hit)
	);

	ppd_match #(.LEN(POST_LEN)) u_post_match (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (advance),
		.rx_byte (rx_byte_s1),
		.pattern (post_pat_q),
		.hit     (post_hit)
	);

	// Store or overflow first, then preamble, then postamble.
	always_comb begin
		logic             col_a;
		logic [CNT_W-1:0] cnt_a;
		col_a          = collecting_q;
		cnt_a          = byte_count_q;
		res_d          = '0;
		res_d.data_byte = rx_byte_s1;
		if (collecting_q) begin
			if (byte_count_q < BUF_SIZE_C) begin
				res_d.stored      = 1'b1;
				res_d.store_index = IDX_W'(byte_count_q);
				cnt_a             = byte_count_q + 1'b1;
			end else begin
				res_d.overflow = 1'b1;
				col_a          = 1'b0;
			end
		end
		if (pre_hit) begin
			col_a             = 1'b1;
			cnt_a             = '0;
			res_d.frame_start = 1'b1;
		end
		collecting_d = col_a;
		byte_count_d = cnt_a;
		if (post_hit) begin
			res_d.frame_done    = 1'b1;
			res_d.payload_valid = col_a;
			if (cnt_a > POST_LEN_C) begin
				res_d.payload_length = IDX_W'(cnt_a - POST_LEN_C);
			end
			collecting_d = 1'b0;
			byte_count_d = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			collecting_q <= 1'b0;
			byte_count_q <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (advance) begin
				collecting_q <= collecting_d;
				byte_count_q <= byte_count_d;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_d;
		end
	end

	// Output packing.
	assign m_tvalid = out_valid_q;
	assign m_tlast  = res_q.frame_done;
	assign m_tdata  = TDATA_W'({res_q.overflow, res_q.payload_valid, res_q.payload_length,
		res_q.frame_start, res_q.store_index, res_q.stored, res_q.data_byte});

	// The count never runs beyond the buffer size.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		byte_count_q <= BUF_SIZE_C)
		else $error("byte count beyond buffer size");

	// A processed byte always lands in the result register on the next cycle.
	a_result_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> m_tvalid)
		else $error("processed byte produced no result");

	// A byte is never both stored and reported as overflow.
	a_store_ovf: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(res_q.stored && res_q.overflow))
		else $error("stored and overflow together");

	// Payload status is only reported with a completed postamble.
	a_pvalid_done: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (res_q.frame_done || (!res_q.payload_valid && res_q.payload_length == '0)))
		else $error("payload status without frame completion");

	// A completed postamble always leaves the block not collecting with a clear count.
	a_done_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && post_hit) |=> (!collecting_q && byte_count_q == '0))
		else $error("collection state not cleared after postamble");

	// Tie-off check on the packed width, so the padding stays zero.
	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[TDATA_W-1:PACK_W] == '0))
		else $error("padding bits of m_tdata not zero");

endmodule
